// ----- rtl/core/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

  // Text buffer size in bytes; must be a power of two between 1024 and 65536.
  localparam int BUFFER_BYTES = 32768;
  localparam int OFS_W        = $clog2(BUFFER_BYTES);
  localparam int LINE_BITS    = 9;
  localparam int PORT_OFS_W   = 15;
  localparam int LINES_W      = 7;
  localparam int STYLE_W      = 8;
  localparam int CHAR_W       = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [LINES_W-1:0] SCREEN_LINES_RESET  = 7'd45;
  localparam logic [STYLE_W-1:0] STYLE_RESET         = 8'd15;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    REG_SCREEN_LINES  = 2'd0,
    REG_TEXT_STYLE    = 2'd1,
    REG_DEFAULT_STYLE = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_CELL   = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_SCROLL = 2'd2,
    KIND_SERIAL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_CHAR      = 2'd0,
    OP_NEWLINE   = 2'd1,
    OP_BACKSPACE = 2'd2
  } op_t;

  // Result steps, emitted in this order for one transaction.
  localparam int STEP_CELL     = 0;
  localparam int STEP_BS_ECHO  = 1;
  localparam int STEP_SP_ECHO  = 2;
  localparam int STEP_CLEAR    = 3;
  localparam int STEP_SCROLL   = 4;
  localparam int STEP_SERIAL   = 5;
  localparam int STEP_N        = 6;

  typedef logic [STEP_N-1:0] step_mask_t;

  typedef struct packed {
    op_t                     op;
    logic [CHAR_W-1:0]       char_code;
    logic [STYLE_W-1:0]      text_style;
    logic [PORT_OFS_W-1:0]   cell_ofs;
    logic                    do_scroll;
    logic [PORT_OFS_W-1:0]   clear_ofs;
    logic [STYLE_W-1:0]      clear_style;
    logic [PORT_OFS_W-1:0]   scroll_ofs;
  } desc_t;

  function automatic logic [PORT_OFS_W-1:0] port_ofs(input logic [OFS_W-1:0] v);
    logic [OFS_W+PORT_OFS_W-1:0] w;
    w = (OFS_W+PORT_OFS_W)'(v);
    return w[PORT_OFS_W-1:0];
  endfunction

  function automatic logic [OFS_W-1:0] lines_to_end(input logic [LINES_W-1:0] lines);
    logic [LINES_W+LINE_BITS-1:0] prod;
    prod = {lines, {LINE_BITS{1'b0}}};
    return prod[OFS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/text_console_writer_top.sv -----
// A character's descriptor is queued, then its first result is registered for the result ports.
// Throughput: the front takes one character per cycle while the four-entry queue has room;
// the back emits a result per cycle while popped; a character makes 1-6 results (2 typical).
// Reset is synchronous and active low; it restores cursor, scroll offset, screen end
// and styles to their power-on values and empties the queue and result register.
`default_nettype none

module text_console_writer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      in_char_code,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [1:0]                           out_kind,
  output logic [14:0]                          out_offset,
  output logic [15:0]                          out_payload,
  output logic                                 out_last,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [7:0]                      cfg_wdata
);
  import tcw_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_wdata, q_rdata;

  tcw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_char_code (in_char_code),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_push       (q_push),
    .q_desc       (q_wdata),
    .q_full       (q_full)
  );

  tcw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  tcw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_rdata),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_kind    (out_kind),
    .out_offset  (out_offset),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_last_is_serial: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> (out_kind == KIND_SERIAL))
    else $error("final result of a character is not its serial echo");

  a_scroll_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_kind == KIND_CLEAR) |=> (!empty && out_kind == KIND_SCROLL))
    else $error("line clear not followed by scroll update");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/tcw_front.sv -----
`default_nettype none

module tcw_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [tcw_pkg::STYLE_W-1:0]  cfg_wdata,
  output logic                              q_push,
  output tcw_pkg::desc_t                    q_desc,
  input  wire logic                         q_full
);
  import tcw_pkg::*;

  logic [OFS_W-1:0]   cursor_r, cursor_nxt;
  logic [OFS_W-1:0]   screen_end_r, screen_end_nxt;
  logic [OFS_W-1:0]   scroll_r, scroll_nxt;
  logic [STYLE_W-1:0] text_style_r, text_style_nxt;
  logic [STYLE_W-1:0] default_style_r, default_style_nxt;

  logic [OFS_W-1:0]           cell_ofs;
  logic [OFS_W-1:0]           cur_new;
  logic [OFS_W-LINE_BITS-1:0] next_line;
  logic                       hit_end;
  op_t                        op;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    next_line = cursor_r[OFS_W-1:LINE_BITS] + 1'b1;
    op        = OP_CHAR;
    cell_ofs  = cursor_r;
    cur_new   = cursor_r + OFS_W'(2);
    if (in_char_code == CHAR_NEWLINE) begin
      op      = OP_NEWLINE;
      cur_new = {next_line, {LINE_BITS{1'b0}}};
    end else if (in_char_code == CHAR_BACKSPACE) begin
      op       = OP_BACKSPACE;
      cell_ofs = cursor_r - OFS_W'(2);
      cur_new  = cell_ofs;
    end
    hit_end = (cur_new == screen_end_r);

    q_desc.op          = op;
    q_desc.char_code   = in_char_code;
    q_desc.text_style  = text_style_r;
    q_desc.cell_ofs    = port_ofs(cell_ofs);
    q_desc.do_scroll   = hit_end;
    q_desc.clear_ofs   = port_ofs(cur_new);
    q_desc.clear_style = default_style_r;
    q_desc.scroll_ofs  = port_ofs(scroll_r + OFS_W'(1 << LINE_BITS));
  end

  always_comb begin
    cursor_nxt        = cursor_r;
    screen_end_nxt    = screen_end_r;
    scroll_nxt        = scroll_r;
    text_style_nxt    = text_style_r;
    default_style_nxt = default_style_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_LINES:  screen_end_nxt    = lines_to_end(cfg_wdata[LINES_W-1:0]);
        REG_TEXT_STYLE:    text_style_nxt    = cfg_wdata;
        REG_DEFAULT_STYLE: default_style_nxt = cfg_wdata;
        default: ;
      endcase
    end else if (q_push) begin
      cursor_nxt = cur_new;
      if (hit_end) begin
        screen_end_nxt = screen_end_r + OFS_W'(1 << LINE_BITS);
        scroll_nxt     = scroll_r + OFS_W'(1 << LINE_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r        <= '0;
      screen_end_r    <= lines_to_end(SCREEN_LINES_RESET);
      scroll_r        <= '0;
      text_style_r    <= STYLE_RESET;
      default_style_r <= STYLE_RESET;
    end else begin
      cursor_r        <= cursor_nxt;
      screen_end_r    <= screen_end_nxt;
      scroll_r        <= scroll_nxt;
      text_style_r    <= text_style_nxt;
      default_style_r <= default_style_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcw_queue.sv -----
`default_nettype none

module tcw_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_push,
  input  wire tcw_pkg::desc_t q_wdata,
  output logic                q_full,
  input  wire logic           q_pop,
  output tcw_pkg::desc_t      q_rdata,
  output logic                q_empty
);
  import tcw_pkg::*;

  desc_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign q_full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcw_back.sv -----
`default_nettype none

module tcw_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_empty,
  input  wire tcw_pkg::desc_t                  q_head,
  output logic                                 q_pop,
  input  wire logic                            pop,
  output logic                                 empty,
  output logic [1:0]                           out_kind,
  output logic [tcw_pkg::PORT_OFS_W-1:0]       out_offset,
  output logic [15:0]                          out_payload,
  output logic                                 out_last
);
  import tcw_pkg::*;

  step_mask_t done_r, done_nxt;
  step_mask_t need, remaining, sel;
  logic       emit, last;

  logic                  valid_r, valid_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [PORT_OFS_W-1:0] offset_r, offset_nxt;
  logic [15:0]           payload_r, payload_nxt;
  logic                  last_r, last_nxt;

  always_comb begin
    need               = '0;
    need[STEP_CELL]    = (q_head.op != OP_NEWLINE);
    need[STEP_BS_ECHO] = (q_head.op == OP_BACKSPACE);
    need[STEP_SP_ECHO] = (q_head.op == OP_BACKSPACE);
    need[STEP_CLEAR]   = q_head.do_scroll;
    need[STEP_SCROLL]  = q_head.do_scroll;
    need[STEP_SERIAL]  = 1'b1;
    remaining = need & ~done_r;
    // Lowest pending step goes first.
    sel  = remaining & (~remaining + 1'b1);
    last = (remaining == sel);
  end

  assign emit  = !q_empty && (!valid_r || pop);
  assign q_pop = emit && last;

  always_comb begin
    kind_nxt    = kind_r;
    offset_nxt  = offset_r;
    payload_nxt = payload_r;
    last_nxt    = last_r;
    valid_nxt   = valid_r && !pop;
    done_nxt    = done_r;
    if (emit) begin
      valid_nxt = 1'b1;
      last_nxt  = last;
      done_nxt  = last ? '0 : (done_r | sel);
      kind_nxt    = KIND_SERIAL;
      offset_nxt  = '0;
      payload_nxt = {8'd0, q_head.char_code};
      if (sel[STEP_CELL]) begin
        kind_nxt    = KIND_CELL;
        offset_nxt  = q_head.cell_ofs;
        payload_nxt = {q_head.text_style,
                       (q_head.op == OP_BACKSPACE) ? 8'd0 : q_head.char_code};
      end else if (sel[STEP_BS_ECHO]) begin
        payload_nxt = {8'd0, CHAR_BACKSPACE};
      end else if (sel[STEP_SP_ECHO]) begin
        payload_nxt = {8'd0, CHAR_SPACE};
      end else if (sel[STEP_CLEAR]) begin
        kind_nxt    = KIND_CLEAR;
        offset_nxt  = q_head.clear_ofs;
        payload_nxt = {8'd0, q_head.clear_style};
      end else if (sel[STEP_SCROLL]) begin
        kind_nxt    = KIND_SCROLL;
        offset_nxt  = q_head.scroll_ofs;
        payload_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    offset_r  <= offset_nxt;
    payload_r <= payload_nxt;
    last_r    <= last_nxt;
  end

  assign empty       = !valid_r;
  assign out_kind    = kind_r;
  assign out_offset  = offset_r;
  assign out_payload = payload_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire
